// ===== src/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg: shared constants and helpers for the ascii number parser
// Character codes, phase and radix codes, and the digit decode function.
// ----------------------------------------------------------------------------
`default_nettype none

package asc_pkg;

  // accumulator, result, character, digit and radix widths
  localparam int VALUE_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 6;
  localparam int RADIX_W     = 5;

  // parse phase codes
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // radix codes
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_BIN = 5'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  // digit value that no radix accepts
  localparam logic [DIGIT_W-1:0] BAD_DIGIT    = 6'd36;
  localparam logic [DIGIT_W-1:0] LETTER_BASE  = 6'd10;

  // result passed from the parser to the output register
  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             ok;
  } result_t;

  // fold lower-case letters onto upper case
  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    u = c;
    if (c >= CH_LA && c <= CH_LZ) begin
      u = c - CASE_OFS;
    end
    return u;
  endfunction

  // value of a digit character, or the bad code
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0]  u;
    logic [CHAR_W-1:0]  ofs;
    logic [DIGIT_W-1:0] d;
    u   = to_upper(c);
    ofs = '0;
    d   = BAD_DIGIT;
    if (u >= CH_ZERO && u <= CH_NINE) begin
      ofs = u - CH_ZERO;
      d   = ofs[DIGIT_W-1:0];
    end else if (u >= CH_UA && u <= CH_UZ) begin
      ofs = u - CH_UA;
      d   = ofs[DIGIT_W-1:0] + LETTER_BASE;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/asc_in_stage.sv =====
// ----------------------------------------------------------------------------
// asc_in_stage: input character register
// Holds one accepted character until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [asc_pkg::CHAR_W-1:0] in_tdata,
  input  wire logic                      out_free,
  output logic                           chr_fire,
  output logic [asc_pkg::CHAR_W-1:0]     chr_code
);

  logic                       vld_r;
  logic                       vld_nxt;
  logic [asc_pkg::CHAR_W-1:0] chr_r;
  logic                       is_term;

  // a terminator needs room in the result register, other characters never wait
  assign is_term   = (chr_r == asc_pkg::CH_NUL);
  assign chr_fire  = vld_r && (!is_term || out_free);
  assign in_tready = !vld_r || chr_fire;
  assign chr_code  = chr_r;

  // occupancy of the register
  always_comb begin
    vld_nxt = vld_r;
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end else if (chr_fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // character payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      chr_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/asc_parse.sv =====
// ----------------------------------------------------------------------------
// asc_parse: base detection and accumulator update
// One character per cycle while chr_fire is high: prefix tracking, digit check and value * radix + digit.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_parse (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       chr_fire,
  input  wire logic [asc_pkg::CHAR_W-1:0] chr_code,
  output logic                            res_valid,
  output asc_pkg::result_t                res
);

  logic [1:0]                          phase_r, phase_nxt;
  logic [asc_pkg::RADIX_W-1:0]         radix_r, radix_nxt;
  logic [asc_pkg::VALUE_WIDTH-1:0]     acc_r, acc_nxt;
  logic                                failed_r, failed_nxt;

  logic [asc_pkg::RADIX_W-1:0]         eff_radix;
  logic                                take_en;
  logic [asc_pkg::DIGIT_W-1:0]         digit;
  logic [asc_pkg::CHAR_W-1:0]          upper;
  logic [asc_pkg::VALUE_WIDTH-1:0]     scaled;
  logic                                is_term;

  assign digit   = asc_pkg::digit_of(chr_code);
  assign upper   = asc_pkg::to_upper(chr_code);
  assign is_term = (chr_code == asc_pkg::CH_NUL);

  // prefix handling picks the radix for this character and whether it is a digit
  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    eff_radix = radix_r;
    take_en   = 1'b0;
    unique case (phase_r)
      asc_pkg::PH_START: begin
        if (chr_code == asc_pkg::CH_ZERO) begin
          phase_nxt = asc_pkg::PH_ZERO;
        end else begin
          phase_nxt = asc_pkg::PH_DIGITS;
          radix_nxt = asc_pkg::RADIX_DEC;
          eff_radix = asc_pkg::RADIX_DEC;
          take_en   = 1'b1;
        end
      end
      asc_pkg::PH_ZERO: begin
        phase_nxt = asc_pkg::PH_DIGITS;
        if (upper == asc_pkg::CH_UX) begin
          radix_nxt = asc_pkg::RADIX_HEX;
        end else if (upper == asc_pkg::CH_UB) begin
          radix_nxt = asc_pkg::RADIX_BIN;
        end else begin
          radix_nxt = asc_pkg::RADIX_OCT;
          eff_radix = asc_pkg::RADIX_OCT;
          take_en   = 1'b1;
        end
      end
      default: begin
        take_en = 1'b1;
      end
    endcase
  end

  // multiply by the radix with shifts and, for decimal, one add
  always_comb begin
    unique case (eff_radix)
      asc_pkg::RADIX_HEX: scaled = acc_r << 4;
      asc_pkg::RADIX_OCT: scaled = acc_r << 3;
      asc_pkg::RADIX_BIN: scaled = acc_r << 1;
      default:            scaled = (acc_r << 3) + (acc_r << 1);
    endcase
  end

  // accumulate or flag a bad character
  always_comb begin
    acc_nxt    = acc_r;
    failed_nxt = failed_r;
    if (take_en && !failed_r) begin
      if (digit < asc_pkg::DIGIT_W'(eff_radix)) begin
        acc_nxt = scaled + asc_pkg::VALUE_WIDTH'(digit);
      end else begin
        failed_nxt = 1'b1;
      end
    end
  end

  // result on the terminator
  assign res_valid = chr_fire && is_term;
  assign res.value = asc_pkg::OUT_W'(acc_r);
  assign res.ok    = !failed_r;

  // parse state, back to start after each string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= asc_pkg::PH_START;
      radix_r  <= asc_pkg::RADIX_DEC;
      acc_r    <= '0;
      failed_r <= 1'b0;
    end else if (chr_fire) begin
      if (is_term) begin
        phase_r  <= asc_pkg::PH_START;
        radix_r  <= asc_pkg::RADIX_DEC;
        acc_r    <= '0;
        failed_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        radix_r  <= radix_nxt;
        acc_r    <= acc_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/asc_out_stage.sv =====
// ----------------------------------------------------------------------------
// asc_out_stage: result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_out_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      res_valid,
  input  wire asc_pkg::result_t          res,
  output logic                           out_free,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [asc_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tuser
);

  logic             vld_r;
  logic             vld_nxt;
  asc_pkg::result_t res_r;

  assign out_free   = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.value;
  assign out_tuser  = res_r.ok;

  // occupancy of the result register
  always_comb begin
    vld_nxt = vld_r;
    if (res_valid) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== src/ascii_number_parser_auto_base.sv =====
// ----------------------------------------------------------------------------
// ascii_number_parser_auto_base: ASCII to unsigned integer with base prefix
// Parses zero-terminated strings; 0x/0X hex, 0b/0B binary, leading 0 octal.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one ASCII character per request in in_tdata; a zero byte ends
//           the string and is the only character that produces a result.
//   out_* : one result per string: parsed value in out_tdata (modulo
//           2^VALUE_WIDTH, partial on a bad character) and ok in out_tuser.
// Throughput: one character per cycle, back to back, except that a terminator
//   waits while the result register is full; the parse step (radix shift-add
//   and digit check) finishes in the cycle after the character is registered.
// Path: an accepted terminator goes through the input register, then the
//   result register, before it shows on out_tvalid.
// Reset: rst_n low clears both registers and returns the parser to the start
//   of a string in decimal with a zero accumulator.
// Stall: while a result waits for out_tready, non-terminator characters keep
//   flowing; a following terminator waits in the input register and in_tready
//   drops until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_number_parser_auto_base (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] char_code
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [31:0]                     out_tdata,  // [31:0] value
  output logic                            out_tuser   // [0] ok
);

  logic                       out_free;
  logic                       chr_fire;
  logic [asc_pkg::CHAR_W-1:0] chr_code;
  logic                       res_valid;
  asc_pkg::result_t           res;

  // input character register
  asc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_free  (out_free),
    .chr_fire  (chr_fire),
    .chr_code  (chr_code)
  );

  // parse state and accumulator
  asc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .chr_fire  (chr_fire),
    .chr_code  (chr_code),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  asc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== src/asc_checker.sv =====
// ----------------------------------------------------------------------------
// asc_checker: port-level checks for the ascii number parser
// Watches the top-level channels and is attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // input only stalls while a result is held back
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with room for a result");

endmodule

bind ascii_number_parser_auto_base asc_checker u_asc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
